### hw/rtl/fetu_pkg.sv
// Shared types and constants for the escape-time fractal iterator.
// Used by fetu_cfg_regs, fetu_mul and escape_time_fractal_iterator_unit.
// No dependencies.
package fetu_pkg;

  // Number formats
  localparam int COORD_W   = 32;               // signed coordinate width
  localparam int FRAC_BITS = 28;               // fraction bits of coordinates
  localparam int ITER_W    = 16;               // iteration counter width
  localparam int NORM_W    = 36;               // unsigned squared-norm width
  localparam int SQ_W      = NORM_W - 1;       // one square, always below 2^(NORM_W-1)
  localparam int OPND_W    = COORD_W + 1;      // multiplier operand (holds |min|)
  localparam int PROD_W    = 2 * COORD_W;      // kept product width
  localparam int X_W       = PROD_W - (FRAC_BITS - 1); // cross term 2*a*b
  localparam int NEXT_W    = COORD_W + 6;      // candidate new z component

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = NORM_W;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_RE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_IM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_NORM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd5;

  localparam logic [NORM_W-1:0] BAILOUT_RESET    = 36'd1073741824;  // 4.0 in Q8.28
  localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = 16'd256;

  // Iteration formula codes
  localparam logic [3:0] VAR_STANDARD   = 4'd0;
  localparam logic [3:0] VAR_CONJUGATE  = 4'd1;
  localparam logic [3:0] VAR_BURN_SHIP  = 4'd2;
  localparam logic [3:0] VAR_RE_ABS_IM  = 4'd3;
  localparam logic [3:0] VAR_ABS_RE_NIM = 4'd4;
  localparam logic [3:0] VAR_ABS_S      = 4'd5;
  localparam logic [3:0] VAR_ABS_S_CONJ = 4'd6;
  localparam logic [3:0] VAR_ABS_BOTH   = 4'd7;
  localparam logic [3:0] VAR_ABS_S_REAI = 4'd8;
  localparam logic [3:0] VAR_ABS_S_NARI = 4'd9;

  typedef struct packed {
    logic [3:0]                variant;
    logic                      julia_mode;
    logic signed [COORD_W-1:0] const_re;
    logic signed [COORD_W-1:0] const_im;
    logic [NORM_W-1:0]         escape_norm;
    logic [ITER_W-1:0]         iter_limit;
  } cfg_t;

endpackage

### hw/rtl/escape_time_fractal_iterator_unit.sv
// Escape-time fractal iterator: top level with sequencer and datapath.
// Depends on fetu_pkg, fetu_cfg_regs and fetu_mul.
//
// Usage:
//   Input stream s_axis carries one complex point per beat (Q4.28 re, im).
//   Output stream m_axis carries one result per point: escape flag,
//   iteration count and the min / max squared norm of the orbit.
//   Configuration is written through cfg_we / cfg_index / cfg_data while
//   the block is idle; writes take effect on the next point.
//   One signed multiplier is shared by every product of the orbit. Each
//   iteration steps through the cross product, new z, two squares and
//   bailout check; a step that overflows ends at the new-z state, and a
//   zero limit ends the point after the starting z has been squared.
//   s_axis_tready is high only while the block is idle, so one point is in
//   flight at a time. The result is held in an output register until
//   m_axis_tready takes it; the next point is accepted after that beat.
//   Synchronous reset returns the sequencer to idle, drops any held result
//   and loads register defaults (bailout 4.0, limit 256, standard formula).
module escape_time_fractal_iterator_unit (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [fetu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fetu_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Point input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [63:0]                      s_axis_tdata,  // point_re[31:0], point_im[63:32]
  // Result output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [95:0]                      m_axis_tdata   // escaped[0], iteration_count[16:1],
                                                          // min_norm_sq[52:17],
                                                          // max_norm_sq[88:53], zero[95:89]
);
  import fetu_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SQR_RE  = 4'd1;
  localparam logic [3:0] ST_SQR_IM  = 4'd2;
  localparam logic [3:0] ST_SQR_END = 4'd3;
  localparam logic [3:0] ST_CHECK   = 4'd4;
  localparam logic [3:0] ST_CROSS   = 4'd5;
  localparam logic [3:0] ST_NEW     = 4'd6;
  localparam logic [3:0] ST_DONE    = 4'd7;

  cfg_t cfg;

  logic [3:0]                state;
  logic                      init;
  logic signed [COORD_W-1:0] zr, zi, cr, ci;
  logic [SQ_W-1:0]           zr2, zi2;
  logic signed [NEXT_W-1:0]  nr;
  logic [ITER_W-1:0]         iter;
  logic [NORM_W-1:0]         min_norm, max_norm;
  logic                      escaped;
  logic [ITER_W-1:0]         count;

  logic                      mul_en;
  logic signed [OPND_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [3:0]                var_eff;
  logic signed [OPND_W-1:0]  zr_x, zi_x, zr_abs, zi_abs, zi_neg;
  logic signed [NORM_W-1:0]  s_diff, s_val;
  logic signed [X_W-1:0]     x_raw, x_val;
  logic signed [NEXT_W-1:0]  nr_sum, ni_sum, x_ext, ci_ext;
  logic                      nr_fits, ni_fits;
  logic [NORM_W-1:0]         n2;
  logic [ITER_W:0]           iter_inc;

  fetu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fetu_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Unknown formula codes fall back to the standard one
  assign var_eff = (cfg.variant > VAR_ABS_S_NARI) ? VAR_STANDARD : cfg.variant;

  // Operand forms of the current z
  always_comb begin
    zr_x   = {zr[COORD_W-1], zr};
    zi_x   = {zi[COORD_W-1], zi};
    zr_abs = zr[COORD_W-1] ? -zr_x : zr_x;
    zi_abs = zi[COORD_W-1] ? -zi_x : zi_x;
    zi_neg = -zi_x;
  end

  // Steer the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = zr_x;
    mul_b  = zi_x;
    case (state)
      ST_SQR_RE: begin
        mul_en = 1'b1;
        mul_a  = zr_x;
        mul_b  = zr_x;
      end
      ST_SQR_IM: begin
        mul_en = 1'b1;
        mul_a  = zi_x;
        mul_b  = zi_x;
      end
      ST_CROSS: begin
        mul_en = 1'b1;
        case (var_eff)
          VAR_BURN_SHIP: begin
            mul_a = zr_abs;
            mul_b = zi_abs;
          end
          VAR_RE_ABS_IM, VAR_ABS_S_REAI: begin
            mul_a = zr_x;
            mul_b = zi_abs;
          end
          VAR_ABS_RE_NIM: begin
            mul_a = zr_abs;
            mul_b = zi_neg;
          end
          VAR_ABS_S_NARI: begin
            mul_a = zr_abs;
            mul_b = zi_x;
          end
          default: begin
            mul_a = zr_x;
            mul_b = zi_x;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Real part: re^2 - im^2, folded for the absolute forms, plus c
  always_comb begin
    s_diff = $signed({1'b0, zr2}) - $signed({1'b0, zi2});
    s_val  = (var_eff >= VAR_ABS_S && s_diff[NORM_W-1]) ? -s_diff : s_diff;
    nr_sum = {{(NEXT_W-NORM_W){s_val[NORM_W-1]}}, s_val}
           + {{(NEXT_W-COORD_W){cr[COORD_W-1]}}, cr};
  end

  // Imaginary part: floored 2*a*b from the product, then add or subtract c
  always_comb begin
    x_raw  = prod[PROD_W-1:FRAC_BITS-1];
    x_val  = (var_eff == VAR_ABS_BOTH && x_raw[X_W-1]) ? -x_raw : x_raw;
    x_ext  = {{(NEXT_W-X_W){x_val[X_W-1]}}, x_val};
    ci_ext = {{(NEXT_W-COORD_W){ci[COORD_W-1]}}, ci};
    if (var_eff == VAR_CONJUGATE || var_eff == VAR_ABS_S_CONJ ||
        var_eff == VAR_ABS_S_NARI) begin
      ni_sum = ci_ext - x_ext;
    end else begin
      ni_sum = ci_ext + x_ext;
    end
    nr_fits = (&nr[NEXT_W-1:COORD_W-1]) || ~(|nr[NEXT_W-1:COORD_W-1]);
    ni_fits = (&ni_sum[NEXT_W-1:COORD_W-1]) || ~(|ni_sum[NEXT_W-1:COORD_W-1]);
  end

  assign n2       = {1'b0, zr2} + {1'b0, zi2};
  assign iter_inc = {1'b0, iter} + 1'b1;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      init  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state    <= ST_SQR_RE;
            init     <= 1'b1;
            iter     <= '0;
            min_norm <= '1;
            max_norm <= '0;
            if (cfg.julia_mode) begin
              zr <= s_axis_tdata[COORD_W-1:0];
              zi <= s_axis_tdata[2*COORD_W-1:COORD_W];
              cr <= cfg.const_re;
              ci <= cfg.const_im;
            end else begin
              zr <= '0;
              zi <= '0;
              cr <= s_axis_tdata[COORD_W-1:0];
              ci <= s_axis_tdata[2*COORD_W-1:COORD_W];
            end
          end
        end
        ST_SQR_RE: state <= ST_SQR_IM;
        ST_SQR_IM: begin
          zr2   <= prod[FRAC_BITS+SQ_W-1:FRAC_BITS];
          state <= ST_SQR_END;
        end
        ST_SQR_END: begin
          zi2   <= prod[FRAC_BITS+SQ_W-1:FRAC_BITS];
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (init) begin
            // Starting z only primes the squares
            init <= 1'b0;
            if (cfg.iter_limit == '0) begin
              escaped <= 1'b0;
              count   <= '0;
              state   <= ST_DONE;
            end else begin
              state <= ST_CROSS;
            end
          end else begin
            if (n2 < min_norm) min_norm <= n2;
            if (n2 > max_norm) max_norm <= n2;
            if (n2 > cfg.escape_norm) begin
              escaped <= 1'b1;
              count   <= iter;
              state   <= ST_DONE;
            end else if (iter_inc == {1'b0, cfg.iter_limit}) begin
              escaped <= 1'b0;
              count   <= cfg.iter_limit;
              state   <= ST_DONE;
            end else begin
              iter  <= iter_inc[ITER_W-1:0];
              state <= ST_CROSS;
            end
          end
        end
        ST_CROSS: begin
          nr    <= nr_sum;
          state <= ST_NEW;
        end
        ST_NEW: begin
          if (!nr_fits || !ni_fits) begin
            // Overflowed step escapes with the norm pinned at full scale
            escaped  <= 1'b1;
            count    <= iter;
            max_norm <= '1;
            state    <= ST_DONE;
          end else begin
            zr    <= nr[COORD_W-1:0];
            zi    <= ni_sum[COORD_W-1:0];
            state <= ST_SQR_RE;
          end
        end
        ST_DONE: begin
          if (m_axis_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Handshakes and result beat
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_DONE);
  assign m_axis_tdata  = {7'd0, max_norm, min_norm, count, escaped};

endmodule

### hw/rtl/fetu_cfg_regs.sv
// Configuration register file of the escape-time fractal iterator.
// Depends on fetu_pkg for register indexes, reset values and cfg_t.
module fetu_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fetu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fetu_pkg::CFG_DATA_W-1:0]  cfg_data,
  output fetu_pkg::cfg_t                   cfg
);
  import fetu_pkg::*;

  // Write one register per beat; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.variant     <= VAR_STANDARD;
      cfg.julia_mode  <= 1'b0;
      cfg.const_re    <= '0;
      cfg.const_im    <= '0;
      cfg.escape_norm <= BAILOUT_RESET;
      cfg.iter_limit  <= ITER_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VARIANT:     cfg.variant     <= cfg_data[3:0];
        REG_JULIA_MODE:  cfg.julia_mode  <= cfg_data[0];
        REG_CONST_RE:    cfg.const_re    <= cfg_data[COORD_W-1:0];
        REG_CONST_IM:    cfg.const_im    <= cfg_data[COORD_W-1:0];
        REG_ESCAPE_NORM: cfg.escape_norm <= cfg_data[NORM_W-1:0];
        REG_ITER_LIMIT:  cfg.iter_limit  <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/fetu_mul.sv
// Shared signed multiplier with a registered product.
// Depends on fetu_pkg for operand and product widths.
module fetu_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [fetu_pkg::OPND_W-1:0]  a,
  input  logic signed [fetu_pkg::OPND_W-1:0]  b,
  output logic signed [fetu_pkg::PROD_W-1:0]  prod
);
  import fetu_pkg::*;

  logic signed [2*OPND_W-1:0] full;

  // Magnitudes never exceed 2^(COORD_W-1), so the product fits PROD_W bits
  assign full = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[PROD_W-1:0];
    end
  end

endmodule

### bench/fetu_orbit_checker.sv
// Scoreboard for the escape-time fractal iterator: mirrors the register file,
// predicts one orbit summary per accepted point and checks every result beat.
// Depends on fetu_pkg for register indexes, formula codes and number formats.
`timescale 1ns / 1ps

module fetu_orbit_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fetu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fetu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [63:0]                      s_tdata,   // point_re[31:0], point_im[63:32]
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [95:0]                      m_tdata,   // escaped[0], iteration_count[16:1],
                                                      // min_norm_sq[52:17],
                                                      // max_norm_sq[88:53], zero[95:89]
  output int                               fault_count,
  output int                               pending
);
  import fetu_pkg::*;

  localparam longint LONG_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint LONG_MIN = -LONG_MAX - 64'sd1;
  localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
  localparam longint COORD_LO = -COORD_HI - 64'sd1;
  localparam logic [63:0] NORM_ALL = (64'd1 << NORM_W) - 64'd1;
  localparam int PRINT_CAP = 40;

  typedef struct {
    logic              escaped;
    logic [ITER_W-1:0] count;
    logic [NORM_W-1:0] min_n;
    logic [NORM_W-1:0] max_n;
  } orbit_sum_t;

  cfg_t       regs;
  orbit_sum_t orbit_q[$];
  orbit_sum_t want;
  int         result_idx;

  initial begin
    fault_count = 0;
    pending     = 0;
    result_idx  = 0;
  end

  // Print one line (up to a cap) and count the fault
  task automatic report_fault(input string msg);
    if (fault_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
    fault_count++;
  endtask

  // floor(a*b / 2^sh) from the exact 128-bit product, saturating to 64 bits
  function automatic longint fix_mul(input longint a, input longint b, input int sh,
                                     inout bit ovf);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    p = p >>> sh;
    if (p[127:63] != {65{p[127]}}) begin
      ovf = 1'b1;
      return p[127] ? LONG_MIN : LONG_MAX;
    end
    return longint'(p[63:0]);
  endfunction

  function automatic longint add_chk(input longint a, input longint b, inout bit ovf);
    longint r;
    r = a + b;
    if ((a < 0) == (b < 0) && (r < 0) != (a < 0)) ovf = 1'b1;
    return r;
  endfunction

  function automatic longint sub_chk(input longint a, input longint b, inout bit ovf);
    longint r;
    r = a - b;
    if ((a < 0) != (b < 0) && (r < 0) != (a < 0)) ovf = 1'b1;
    return r;
  endfunction

  function automatic longint abs_sat(input longint x);
    if (x >= 0) return x;
    if (x == LONG_MIN) return LONG_MAX;
    return -x;
  endfunction

  // Run the whole orbit of one point under the given register settings
  function automatic orbit_sum_t trace_orbit(input cfg_t c,
                                             input logic signed [COORD_W-1:0] pr,
                                             input logic signed [COORD_W-1:0] pi);
    orbit_sum_t res;
    longint zr, zi, cr, ci, zr2, zi2, s, x, nr, ni, nzi;
    logic [63:0] n2, mn, mx;
    logic [3:0] v;
    bit ovf;
    ovf = 1'b0;
    mn  = '1;
    mx  = '0;
    res.escaped = 1'b0;
    res.count   = c.iter_limit;
    v = (c.variant > VAR_ABS_S_NARI) ? VAR_STANDARD : c.variant;
    if (c.julia_mode) begin
      zr = pr;
      zi = pi;
      cr = c.const_re;
      ci = c.const_im;
    end else begin
      zr = 0;
      zi = 0;
      cr = pr;
      ci = pi;
    end
    zr2 = fix_mul(zr, zr, FRAC_BITS, ovf);
    zi2 = fix_mul(zi, zi, FRAC_BITS, ovf);
    for (int it = 0; it < c.iter_limit; it++) begin
      // real part: re^2 - im^2, folded for the abs variants
      s = zr2 - zi2;
      if (v >= VAR_ABS_S) s = abs_sat(s);
      nr = add_chk(s, cr, ovf);
      // cross term 2*re*im with the variant's sign handling
      case (v)
        VAR_BURN_SHIP:
          x = fix_mul(abs_sat(zr), abs_sat(zi), FRAC_BITS - 1, ovf);
        VAR_RE_ABS_IM, VAR_ABS_S_REAI:
          x = fix_mul(zr, abs_sat(zi), FRAC_BITS - 1, ovf);
        VAR_ABS_RE_NIM: begin
          nzi = sub_chk(64'sd0, zi, ovf);
          x = fix_mul(abs_sat(zr), nzi, FRAC_BITS - 1, ovf);
        end
        VAR_ABS_S_NARI:
          x = fix_mul(abs_sat(zr), zi, FRAC_BITS - 1, ovf);
        default:
          x = fix_mul(zr, zi, FRAC_BITS - 1, ovf);
      endcase
      if (v == VAR_ABS_BOTH) x = abs_sat(x);
      if (v == VAR_CONJUGATE || v == VAR_ABS_S_CONJ || v == VAR_ABS_S_NARI)
        ni = sub_chk(ci, x, ovf);
      else
        ni = add_chk(x, ci, ovf);
      if (nr < COORD_LO || nr > COORD_HI || ni < COORD_LO || ni > COORD_HI) ovf = 1'b1;
      if (!ovf) begin
        zr2 = fix_mul(nr, nr, FRAC_BITS, ovf);
        zi2 = fix_mul(ni, ni, FRAC_BITS, ovf);
      end
      // overflow counts as the largest possible norm
      if (ovf) n2 = '1;
      else     n2 = zr2 + zi2;
      if (n2 < mn) mn = n2;
      if (n2 > mx) mx = n2;
      if (ovf || n2 > c.escape_norm) begin
        res.escaped = 1'b1;
        res.count   = ITER_W'(it);
        break;
      end
      zr = nr;
      zi = ni;
    end
    res.min_n = (mn > NORM_ALL) ? NORM_ALL[NORM_W-1:0] : mn[NORM_W-1:0];
    res.max_n = (mx > NORM_ALL) ? NORM_ALL[NORM_W-1:0] : mx[NORM_W-1:0];
    return res;
  endfunction

  // Track register writes, predict on input beats, compare on output beats
  always @(posedge clk) begin
    if (rst) begin
      regs.variant     = VAR_STANDARD;
      regs.julia_mode  = 1'b0;
      regs.const_re    = '0;
      regs.const_im    = '0;
      regs.escape_norm = BAILOUT_RESET;
      regs.iter_limit  = ITER_LIMIT_RESET;
      orbit_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_VARIANT:     regs.variant     = cfg_data[3:0];
          REG_JULIA_MODE:  regs.julia_mode  = cfg_data[0];
          REG_CONST_RE:    regs.const_re    = cfg_data[COORD_W-1:0];
          REG_CONST_IM:    regs.const_im    = cfg_data[COORD_W-1:0];
          REG_ESCAPE_NORM: regs.escape_norm = cfg_data[NORM_W-1:0];
          REG_ITER_LIMIT:  regs.iter_limit  = cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (orbit_q.size() == 0) begin
          report_fault($sformatf("result beat %0d arrived with no point outstanding",
                                 result_idx));
        end else begin
          want = orbit_q.pop_front();
          if (m_tdata[0] !== want.escaped)
            report_fault($sformatf("result %0d escaped: got %0h expected %0h",
                                   result_idx, m_tdata[0], want.escaped));
          if (m_tdata[16:1] !== want.count)
            report_fault($sformatf("result %0d iteration_count: got %0d expected %0d",
                                   result_idx, m_tdata[16:1], want.count));
          if (m_tdata[52:17] !== want.min_n)
            report_fault($sformatf("result %0d min_norm_sq: got %0h expected %0h",
                                   result_idx, m_tdata[52:17], want.min_n));
          if (m_tdata[88:53] !== want.max_n)
            report_fault($sformatf("result %0d max_norm_sq: got %0h expected %0h",
                                   result_idx, m_tdata[88:53], want.max_n));
          if (m_tdata[95:89] !== 7'd0)
            report_fault($sformatf("result %0d padding bits not zero: %0h",
                                   result_idx, m_tdata[95:89]));
        end
        result_idx++;
      end
      if (s_tvalid && s_tready)
        orbit_q.push_back(trace_orbit(regs, s_tdata[31:0], s_tdata[63:32]));
    end
    pending = orbit_q.size();
  end

endmodule

### bench/tb.sv
// Top-level bench for escape_time_fractal_iterator_unit: clock, reset,
// register programming, point stimulus, output back-pressure and verdict.
// Depends on fetu_pkg, the RTL and fetu_orbit_checker.
`timescale 1ns / 1ps

module tb;
  import fetu_pkg::*;

  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int HOLD_CYCLES   = 3000;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_POINTS  = 86;
  localparam int PRESSURE_PHASE = 2;
  // indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [31:0] Q_ONE     = 32'h1000_0000;
  localparam logic [31:0] Q_NEG_TWO = 32'hE000_0000;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic [63:0]           s_axis_tdata = '0;
  logic                  m_axis_tready = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [95:0]           m_axis_tdata;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;
  int fault_count;
  int pending;

  escape_time_fractal_iterator_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fetu_orbit_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .fault_count (fault_count),
    .pending     (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served   <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] q28(input real v);
    return 32'($rtoi(v * 268435456.0));
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(5))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return Q_ONE;
      default: return Q_NEG_TWO;
    endcase
  endfunction

  // Mostly points around the set, some raw noise, some corner values
  function automatic logic [63:0] pick_point();
    int sel;
    logic [31:0] re, im;
    sel = $urandom_range(99);
    if (sel < 70) begin
      re = 32'($urandom_range(1073741824)) - 32'd671088640;  // -2.5 .. 1.5
      im = 32'($urandom_range(805306368)) - 32'd402653184;   // -1.5 .. 1.5
    end else if (sel < 90) begin
      re = $urandom;
      im = $urandom;
    end else begin
      re = corner_value();
      im = corner_value();
    end
    return {im, re};
  endfunction

  // Queue one register write; consecutive calls keep the enable high
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  task automatic reg_write_done();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one point beat after a random gap and hold it until accepted
  task automatic send_point(input logic [31:0] re, input logic [31:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {im, re};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop valid and wait until every predicted result has been checked
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  // New random settings for a phase; junk in the unused data bits
  task automatic randomize_regs();
    logic [3:0]        var_code;
    logic              mode;
    logic [31:0]       jre, jim;
    logic [NORM_W-1:0] bail;
    logic [ITER_W-1:0] limit;
    int                pick;
    var_code = 4'($urandom_range(15));
    mode     = 1'($urandom_range(1));
    if ($urandom_range(3) == 0) begin
      jre = $urandom;
      jim = $urandom;
    end else begin
      jre = 32'($urandom_range(536870912)) - 32'd268435456;  // -1.0 .. 1.0
      jim = 32'($urandom_range(536870912)) - 32'd268435456;
    end
    pick = $urandom_range(9);
    case (pick)
      0:       bail = '0;
      1:       bail = '1;
      2:       bail = {4'($urandom), 32'($urandom)};
      3, 4, 5: bail = BAILOUT_RESET;
      default: bail = 36'($urandom);
    endcase
    pick = $urandom_range(19);
    case (pick)
      0:       limit = '0;
      1:       limit = ITER_W'($urandom_range(200, 100));
      default: limit = ITER_W'($urandom_range(40, 1));
    endcase
    reg_write(REG_VARIANT,     {32'($urandom), var_code});
    reg_write(REG_JULIA_MODE,  {32'($urandom), 3'($urandom), mode});
    reg_write(REG_CONST_RE,    {4'($urandom), jre});
    reg_write(REG_CONST_IM,    {4'($urandom), jim});
    reg_write(REG_ESCAPE_NORM, bail);
    reg_write(REG_ITER_LIMIT,  {20'($urandom), limit});
    reg_write_done();
  endtask

  initial begin
    logic [63:0] beat;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset settings: Mandelbrot, standard formula, bailout 4.0, limit 256
    send_point(32'h0, 32'h0);
    send_point(Q_MIN, Q_MIN);
    send_point(Q_MAX, Q_MAX);
    send_point(q28(-0.75), q28(0.1));
    drain();

    // Every formula, then an unknown code that falls back to standard
    for (int v = 0; v <= 10; v++) begin
      reg_write(REG_VARIANT, (v == 10) ? 36'hF : 36'(v));
      reg_write_done();
      send_point(q28(-1.6), q28(0.45));
      drain();
    end

    // Julia mode; writes to unmapped indexes must not disturb the constant
    reg_write(REG_VARIANT, {32'h0, VAR_STANDARD});
    reg_write(REG_JULIA_MODE, 36'd1);
    reg_write(REG_CONST_RE, {4'h0, q28(-0.8)});
    reg_write(REG_CONST_IM, {4'h0, q28(0.156)});
    reg_write(REG_SPARE_6, '1);
    reg_write(REG_SPARE_7, {4'($urandom), 32'($urandom)});
    reg_write_done();
    send_point(q28(0.3), q28(-0.2));
    send_point(Q_MIN, Q_MAX);
    drain();

    // Zero bailout: any nonzero norm escapes on the first step
    reg_write(REG_JULIA_MODE, 36'd0);
    reg_write(REG_ESCAPE_NORM, '0);
    reg_write_done();
    send_point(q28(0.25), 32'h0);
    drain();

    // Largest bailout: only overflow can make the point escape
    reg_write(REG_ESCAPE_NORM, '1);
    reg_write_done();
    send_point(q28(7.5), 32'h0);
    drain();

    // Iteration limits: zero, one and the largest
    reg_write(REG_ESCAPE_NORM, BAILOUT_RESET);
    reg_write(REG_ITER_LIMIT, 36'd0);
    reg_write_done();
    send_point(q28(-0.5), q28(0.5));
    drain();
    reg_write(REG_ITER_LIMIT, 36'd1);
    reg_write_done();
    send_point(32'h0, 32'h0);
    drain();
    reg_write(REG_ITER_LIMIT, 36'hFFFF);
    reg_write_done();
    send_point(q28(3.0), q28(3.0));
    drain();

    // Random phases, cycling through the idle patterns
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      randomize_regs();
      // hold results back while points keep arriving
      if (ph == PRESSURE_PHASE) hold_requests <= hold_requests + 1;
      for (int n = 0; n < PHASE_POINTS; n++) begin
        beat = pick_point();
        send_point(beat[31:0], beat[63:32]);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fault_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
